[hw/rtl/sample_logger_controller_assert.svh]
// Assertion macros used by the sample logger controller checker.
`ifndef SAMPLE_LOGGER_CONTROLLER_ASSERT_SVH
`define SAMPLE_LOGGER_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SLC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sample logger check failed");

// Next-cycle implication, checked outside reset
`define SLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sample logger check failed");

`endif

[hw/rtl/slc_pkg.sv]
// Package with shared types and constants of the sample logger controller.
package slc_pkg;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_POLL_SECONDS = 2'd0;
    localparam logic [1:0] REG_LOG_SLOTS    = 2'd1;
    localparam logic [1:0] REG_FIRST_SLOT   = 2'd2;

    // Register reset values
    localparam logic [7:0] POLL_SECONDS_RESET = 8'd5;
    localparam logic [8:0] LOG_SLOTS_RESET    = 9'd224;
    localparam logic [7:0] FIRST_SLOT_RESET   = 8'd0;

    // Tracker reset values
    localparam logic [15:0] LOWEST_RESET  = 16'hffff;
    localparam logic [15:0] HIGHEST_RESET = 16'h0000;

    // One result word, packed exactly as on m_tdata (led_on in bit 0)
    typedef struct packed {
        logic        recording;
        logic [15:0] write_data;
        logic [7:0]  write_index;
        logic        write_valid;
        logic        led_on;
    } slc_result_t;

    // Configuration seen by the step logic
    typedef struct packed {
        logic [7:0] poll_seconds;
        logic [8:0] log_end;
        logic       slot_load;
        logic [7:0] first_slot;
    } slc_cfg_t;

endpackage

[hw/rtl/sample_logger_controller.sv]
// Path: a sample's result words pass through the input register, then the result buffer.
// Throughput: one sample per cycle while the single result buffer is free; a tick that logs min
// and max sends three words, one per cycle on m_tready, holding the input until its last leaves.
// Reset: control, counters and trackers clear (min 0xffff, max 0, next slot 0),
// registers return to poll 5, log slots 224, first slot 0; no clearing pass.
module sample_logger_controller #(
    parameter int unsigned LOG_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] sample, [16] button_pressed, [23:17] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: [0] led_on, [1] write_valid, [9:2] write_index, [25:10] write_data,
    // [26] recording, [31:27] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned DepthCap = (LOG_DEPTH > 511) ? 511 : LOG_DEPTH;

    logic        in_valid_reg;
    logic [15:0] in_sample_reg;
    logic        in_button_reg;
    logic [7:0]  poll_reg;
    logic [8:0]  slots_reg;
    logic [7:0]  first_reg;
    logic        cfg_write, advance, can_load;
    logic [1:0]  result_count;

    slc_pkg::slc_cfg_t               cfg;
    slc_pkg::slc_result_t [2:0]      results;
    slc_pkg::slc_result_t            out_result;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_reg  <= slc_pkg::POLL_SECONDS_RESET;
            slots_reg <= slc_pkg::LOG_SLOTS_RESET;
            first_reg <= slc_pkg::FIRST_SLOT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                slc_pkg::REG_POLL_SECONDS: poll_reg  <= pwdata[7:0];
                slc_pkg::REG_LOG_SLOTS:    slots_reg <= pwdata[8:0];
                slc_pkg::REG_FIRST_SLOT:   first_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            slc_pkg::REG_POLL_SECONDS: prdata = {24'd0, poll_reg};
            slc_pkg::REG_LOG_SLOTS:    prdata = {23'd0, slots_reg};
            slc_pkg::REG_FIRST_SLOT:   prdata = {24'd0, first_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Effective end of log and slot reload
    assign cfg.poll_seconds = poll_reg;
    assign cfg.log_end      = (slots_reg > 9'(DepthCap)) ? 9'(DepthCap) : slots_reg;
    assign cfg.slot_load    = cfg_write && (paddr[3:2] == slc_pkg::REG_FIRST_SLOT);
    assign cfg.first_slot   = pwdata[7:0];

    // Input register; advance when the result buffer takes the tick
    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[15:0];
            in_button_reg <= s_tdata[16];
        end
    end

    slc_step u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .sample         (in_sample_reg),
        .button_pressed (in_button_reg),
        .cfg            (cfg),
        .results        (results),
        .result_count   (result_count)
    );

    slc_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (advance),
        .load_results (results),
        .load_count   (result_count),
        .can_load     (can_load),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (out_result),
        .out_last     (m_tlast)
    );

    // Pack the result word
    assign m_tdata = {5'd0, out_result.recording, out_result.write_data,
                      out_result.write_index, out_result.write_valid, out_result.led_on};

endmodule

[hw/rtl/slc_step.sv]
// Per-tick step logic and controller state of the sample logger.
module slc_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [15:0]                   sample,
    input  logic                          button_pressed,
    input  slc_pkg::slc_cfg_t             cfg,
    output slc_pkg::slc_result_t [2:0]    results,
    output logic [1:0]                    result_count
);

    logic [1:0]  phase_reg, phase_next;
    logic        rec_reg, rec_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [8:0]  slot_reg, slot_next;
    logic [15:0] lo_reg, lo_next;
    logic [15:0] hi_reg, hi_next;
    logic        led_reg, led_next;

    logic        phase0, rec_t, log_now, stop;
    logic [7:0]  cnt_t, cnt_i;
    logic [8:0]  slot_b, slot_c, slot_d;
    logic [2:0]  wr_valid;

    // Saturating slot advance
    function automatic logic [8:0] slot_inc(input logic [8:0] s);
        return (s == 9'h1ff) ? s : s + 9'd1;
    endfunction

    // Slot chain for the sample, minimum and maximum writes
    assign slot_b = slot_inc(slot_reg);
    assign slot_c = slot_inc(slot_b);
    assign slot_d = slot_inc(slot_c);
    assign stop   = ({1'b0, slot_b} + 10'd2) >= {1'b0, cfg.log_end};

    // Second-boundary decisions
    assign phase0  = (phase_reg == 2'd0);
    assign rec_t   = rec_reg ^ button_pressed;
    assign cnt_t   = (button_pressed && rec_t) ? 8'd0 : cnt_reg;
    assign cnt_i   = (cnt_t == 8'hff) ? cnt_t : cnt_t + 8'd1;
    assign log_now = phase0 && rec_t && (cnt_i >= cfg.poll_seconds);

    // Writes past the end of the log are dropped
    assign wr_valid[0] = log_now && (slot_reg < cfg.log_end);
    assign wr_valid[1] = log_now && stop && (slot_b < cfg.log_end);
    assign wr_valid[2] = log_now && stop && (slot_c < cfg.log_end);

    // Next state
    always_comb begin
        phase_next = phase_reg + 2'd1;
        lo_next    = (sample < lo_reg) ? sample : lo_reg;
        hi_next    = (sample > hi_reg) ? sample : hi_reg;
        rec_next   = rec_reg;
        cnt_next   = cnt_reg;
        led_next   = led_reg;
        slot_next  = slot_reg;
        if (phase0) begin
            rec_next = rec_t;
            cnt_next = cnt_t;
            if (rec_t) begin
                led_next = 1'b1;
                cnt_next = log_now ? 8'd0 : cnt_i;
            end
            if (log_now) begin
                if (stop) begin
                    slot_next = slot_d;
                    rec_next  = 1'b0;
                end else begin
                    slot_next = slot_b;
                end
            end
        end else if (rec_reg) begin
            led_next = 1'b0;
        end
    end

    // Result words; valid writes always form a prefix
    always_comb begin
        results[0].write_valid = wr_valid[0];
        results[0].write_index = wr_valid[0] ? slot_reg[7:0] : 8'd0;
        results[0].write_data  = wr_valid[0] ? sample : 16'd0;
        results[1].write_valid = wr_valid[1];
        results[1].write_index = wr_valid[1] ? slot_b[7:0] : 8'd0;
        results[1].write_data  = wr_valid[1] ? lo_reg : 16'd0;
        results[2].write_valid = wr_valid[2];
        results[2].write_index = wr_valid[2] ? slot_c[7:0] : 8'd0;
        results[2].write_data  = wr_valid[2] ? hi_reg : 16'd0;
        for (int i = 0; i < 3; i++) begin
            results[i].led_on    = led_next;
            results[i].recording = rec_next;
        end
        if (wr_valid[2]) begin
            result_count = 2'd3;
        end else if (wr_valid[1]) begin
            result_count = 2'd2;
        end else begin
            result_count = 2'd1;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            rec_reg   <= 1'b0;
            cnt_reg   <= 8'd0;
            slot_reg  <= {1'b0, slc_pkg::FIRST_SLOT_RESET};
            lo_reg    <= slc_pkg::LOWEST_RESET;
            hi_reg    <= slc_pkg::HIGHEST_RESET;
            led_reg   <= 1'b0;
        end else if (cfg.slot_load) begin
            slot_reg  <= {1'b0, cfg.first_slot};
        end else if (advance) begin
            phase_reg <= phase_next;
            rec_reg   <= rec_next;
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            led_reg   <= led_next;
        end
    end

endmodule

[hw/rtl/slc_emit.sv]
// Result buffer sending up to three words of a tick, one per cycle on out_ready.
module slc_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  slc_pkg::slc_result_t [2:0]    load_results,
    input  logic [1:0]                    load_count,
    output logic                          can_load,
    output logic                          out_valid,
    input  logic                          out_ready,
    output slc_pkg::slc_result_t          out_result,
    output logic                          out_last
);

    slc_pkg::slc_result_t [2:0] ent_reg, ent_next;
    logic [1:0]                 left_reg, left_next;

    // Buffer frees up when empty or when its final word leaves now
    assign can_load   = (left_reg == 2'd0) || ((left_reg == 2'd1) && out_ready);
    assign out_valid  = (left_reg != 2'd0);
    assign out_result = ent_reg[0];
    assign out_last   = (left_reg == 2'd1);

    // Load a new tick or shift out the word taken
    always_comb begin
        ent_next  = ent_reg;
        left_next = left_reg;
        if (load) begin
            ent_next  = load_results;
            left_next = load_count;
        end else if (out_valid && out_ready) begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            left_next   = left_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= 2'd0;
        end else begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

[hw/rtl/slc_checker.sv]
// Port-level checker for the sample logger controller and its bind.
`include "sample_logger_controller_assert.svh"

module slc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // Stalled word holds
    `SLC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // A word that writes nothing carries zero index and data
    `SLC_ASSERT_NOW(a_idle_zero, aclk, aresetn, m_tvalid && !m_tdata[1], m_tdata[25:2] == 24'd0)

    // Only writes are followed by more words of the same tick
    `SLC_ASSERT_NOW(a_multi_write, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[1])

    // Words of one tick go to consecutive slots
    `SLC_ASSERT_NEXT(a_slot_seq, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[9:2] == $past(m_tdata[9:2]) + 8'd1))

    // LED and recording flag agree across words of one tick
    `SLC_ASSERT_NEXT(a_flags_same, aclk, aresetn, m_tvalid && m_tready && !m_tlast, (m_tdata[0] == $past(m_tdata[0])) && (m_tdata[26] == $past(m_tdata[26])))

endmodule

bind sample_logger_controller slc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[dv/testbench.sv]
// Self-checking testbench for the sample logger controller: directed plan, then random runs.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned LOG_DEPTH = 256;

    // One expected result word plus its end-of-tick marker
    typedef struct packed {
        slc_pkg::slc_result_t word;
        logic                 last;
    } log_word_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // One line of the directed plan: a sample word or a register write
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        logic [15:0] smp;
        logic        btn;
        logic        typed;
        logic        led;
        logic        rec;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sample_logger_controller u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Predictor copy of the registers and the logger state
    logic [7:0]  cfg_poll  = slc_pkg::POLL_SECONDS_RESET;
    logic [8:0]  cfg_slots = slc_pkg::LOG_SLOTS_RESET;
    logic [1:0]  beat_phase = '0;
    logic        rec_active = 1'b0;
    logic [7:0]  sec_tally = '0;
    logic [8:0]  slot_ptr = {1'b0, slc_pkg::FIRST_SLOT_RESET};
    logic [15:0] min_sample = slc_pkg::LOWEST_RESET;
    logic [15:0] max_sample = slc_pkg::HIGHEST_RESET;
    logic        led_state = 1'b0;

    slc_pkg::slc_result_t tick_writes[$];
    log_word_t            tick_results[$];
    log_word_t            pending_log_words[$];

    int gap_pct = 33;
    int stall_pct = 71;
    int mismatches = 0;
    int samples_sent = 0;
    int words_checked = 0;
    int slot_writes_seen = 0;
    int log_closes = 0;

    function automatic int unsigned log_end();
        return (cfg_slots > LOG_DEPTH) ? LOG_DEPTH : int'(cfg_slots);
    endfunction

    // Queue one slot write if it fits the log; advance the slot pointer regardless, saturating at 511
    function void claim_slot(logic [15:0] data);
        slc_pkg::slc_result_t w;
        if (slot_ptr < log_end() && tick_writes.size() < 3) begin
            w = '0;
            w.write_valid = 1'b1;
            w.write_index = slot_ptr[7:0];
            w.write_data = data;
            tick_writes.push_back(w);
        end
        if (slot_ptr < 9'd511)
            slot_ptr++;
    endfunction

    // Advance the logger by one tick and build the words it sends
    function void predict_tick(logic [15:0] smp, logic btn);
        logic [15:0] lo_before;
        logic [15:0] hi_before;
        log_word_t   lw;
        lo_before = min_sample;
        hi_before = max_sample;
        tick_writes.delete();
        tick_results.delete();
        if (beat_phase != 2'd0) begin
            if (rec_active)
                led_state = 1'b0;
        end else begin
            if (btn) begin
                rec_active = ~rec_active;
                if (rec_active)
                    sec_tally = '0;
            end
            if (rec_active) begin
                if (sec_tally != 8'd255)
                    sec_tally++;
                led_state = 1'b1;
                if (sec_tally >= cfg_poll) begin
                    sec_tally = '0;
                    claim_slot(smp);
                    // Near the end of the log: append min and max, then stop
                    if (int'(slot_ptr) + 2 >= int'(log_end())) begin
                        claim_slot(lo_before);
                        claim_slot(hi_before);
                        rec_active = 1'b0;
                        log_closes++;
                    end
                end
            end
        end
        if (min_sample > smp)
            min_sample = smp;
        if (max_sample < smp)
            max_sample = smp;
        beat_phase = beat_phase + 2'd1;
        if (tick_writes.size() == 0)
            tick_writes.push_back('0);
        foreach (tick_writes[i]) begin
            lw.word = tick_writes[i];
            lw.word.led_on = led_state;
            lw.word.recording = rec_active;
            lw.last = (i == tick_writes.size() - 1);
            tick_results.push_back(lw);
        end
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns",
                 what, got, want, $realtime);
    endtask

    // Check every accepted result word against the oldest expectation
    always @(posedge aclk) begin : watch_results
        slc_pkg::slc_result_t got;
        log_word_t            want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[26:0];
            words_checked++;
            if (got.write_valid)
                slot_writes_seen++;
            if (pending_log_words.size() == 0) begin
                note_mismatch("word with nothing expected", m_tdata, '0);
            end else begin
                want = pending_log_words.pop_front();
                if (got.led_on !== want.word.led_on)
                    note_mismatch("led_on", 32'(got.led_on), 32'(want.word.led_on));
                if (got.write_valid !== want.word.write_valid)
                    note_mismatch("write_valid", 32'(got.write_valid),
                                  32'(want.word.write_valid));
                if (got.write_index !== want.word.write_index)
                    note_mismatch("write_index", 32'(got.write_index),
                                  32'(want.word.write_index));
                if (got.write_data !== want.word.write_data)
                    note_mismatch("write_data", 32'(got.write_data),
                                  32'(want.word.write_data));
                if (got.recording !== want.word.recording)
                    note_mismatch("recording", 32'(got.recording), 32'(want.word.recording));
                if (m_tlast !== want.last)
                    note_mismatch("tlast", 32'(m_tlast), 32'(want.last));
                if (m_tdata[31:27] !== 5'd0)
                    note_mismatch("pad bits", 32'(m_tdata[31:27]), '0);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Offer one sample word, with random gaps, and log its expected results
    task automatic send_word(input logic [15:0] smp, input logic btn, input logic typed,
                             input logic t_led, input logic t_rec);
        log_word_t typed_word;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, btn, smp};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_tick(smp, btn);
        if (typed) begin
            typed_word = '0;
            typed_word.word.led_on = t_led;
            typed_word.word.recording = t_rec;
            typed_word.last = 1'b1;
            pending_log_words.push_back(typed_word);
        end else begin
            foreach (tick_results[i])
                pending_log_words.push_back(tick_results[i]);
        end
        samples_sent++;
    endtask

    // Hold the input and wait until every expected word has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_log_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register over the bus once the block has gone quiet
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            slc_pkg::REG_POLL_SECONDS: cfg_poll = val[7:0];
            slc_pkg::REG_LOG_SLOTS:    cfg_slots = val[8:0];
            slc_pkg::REG_FIRST_SLOT:   slot_ptr = {1'b0, val[7:0]};
            default: ;
        endcase
    endtask

    function automatic plan_row_t word_row(logic [15:0] smp, logic btn);
        plan_row_t r;
        r = '{kind: ROW_WORD, reg_idx: '0, reg_val: '0, smp: smp, btn: btn,
              typed: 1'b0, led: 1'b0, rec: 1'b0};
        return r;
    endfunction

    function automatic plan_row_t typed_row(logic [15:0] smp, logic btn, logic led, logic rec);
        plan_row_t r;
        r = word_row(smp, btn);
        r.typed = 1'b1;
        r.led = led;
        r.rec = rec;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [1:0] idx, logic [31:0] val);
        plan_row_t r;
        r = word_row('0, 1'b0);
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial begin : run_stimulus
        plan_row_t   plan[$];
        logic [7:0]  poll_v;
        logic [8:0]  slots_v;
        logic [7:0]  first_v;
        logic [15:0] smp;
        logic        btn;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: only phase-zero ticks act; a press starts, then stops, recording
        plan.push_back(typed_row(16'h1234, 1'b0, 1'b0, 1'b0));
        plan.push_back(typed_row(16'h8000, 1'b1, 1'b0, 1'b0));
        plan.push_back(typed_row(16'h0800, 1'b0, 1'b0, 1'b0));
        plan.push_back(typed_row(16'h7000, 1'b1, 1'b0, 1'b0));
        plan.push_back(typed_row(16'h2000, 1'b1, 1'b1, 1'b1));
        plan.push_back(typed_row(16'h3000, 1'b0, 1'b0, 1'b1));
        plan.push_back(typed_row(16'h3000, 1'b1, 1'b0, 1'b1));
        plan.push_back(typed_row(16'h3000, 1'b0, 1'b0, 1'b1));
        plan.push_back(typed_row(16'h4000, 1'b1, 1'b0, 1'b0));
        plan.push_back(typed_row(16'h4444, 1'b0, 1'b0, 1'b0));
        plan.push_back(typed_row(16'h4444, 1'b1, 1'b0, 1'b0));
        plan.push_back(typed_row(16'h4444, 1'b0, 1'b0, 1'b0));
        // Short log: two samples, then min and max taken before the closing sample
        plan.push_back(reg_row(slc_pkg::REG_POLL_SECONDS, 32'd1));
        plan.push_back(reg_row(slc_pkg::REG_LOG_SLOTS, 32'd6));
        plan.push_back(reg_row(slc_pkg::REG_FIRST_SLOT, 32'd2));
        plan.push_back(word_row(16'h0400, 1'b1));
        plan.push_back(word_row(16'h9000, 1'b0));
        plan.push_back(word_row(16'h0003, 1'b1));
        plan.push_back(word_row(16'h5555, 1'b0));
        plan.push_back(word_row(16'h0001, 1'b0));
        plan.push_back(word_row(16'hffff, 1'b1));
        plan.push_back(word_row(16'h0000, 1'b1));
        plan.push_back(word_row(16'hffff, 1'b0));
        // Last slot of the log: min and max fall past the end and are dropped
        plan.push_back(reg_row(slc_pkg::REG_LOG_SLOTS, 32'd256));
        plan.push_back(reg_row(slc_pkg::REG_FIRST_SLOT, 32'd255));
        plan.push_back(word_row(16'h0000, 1'b1));
        plan.push_back(word_row(16'ha5a5, 1'b0));
        plan.push_back(word_row(16'h5a5a, 1'b1));
        plan.push_back(word_row(16'hffff, 1'b0));
        // Pointer already past the end: nothing written, one idle word
        plan.push_back(reg_row(slc_pkg::REG_LOG_SLOTS, 32'd200));
        plan.push_back(reg_row(slc_pkg::REG_FIRST_SLOT, 32'd255));
        plan.push_back(typed_row(16'hffff, 1'b1, 1'b1, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_word(plan[i].smp, plan[i].btn, plan[i].typed, plan[i].led, plan[i].rec);
        end

        // Random runs, each under its own register setting
        for (int seg = 0; seg < 12; seg++) begin
            case (seg / 4)
                0: begin gap_pct = 33; stall_pct = 71; end
                1: begin gap_pct = 71; stall_pct = 33; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            case (seg)
                0: begin poll_v = 8'd255; slots_v = 9'd511; first_v = 8'd0;   end
                1: begin poll_v = 8'd0;   slots_v = 9'd0;   first_v = 8'd255; end
                2: begin poll_v = 8'd1;   slots_v = 9'd2;   first_v = 8'd0;   end
                3: begin poll_v = 8'd1;   slots_v = 9'd256; first_v = 8'd250; end
                default: begin
                    poll_v = ($urandom_range(0, 9) < 2) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(1, 3));
                    first_v = 8'($urandom_range(0, 255));
                    slots_v = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                          : 9'(first_v) + 9'($urandom_range(0, 10));
                end
            endcase
            write_reg(slc_pkg::REG_POLL_SECONDS, {24'd0, poll_v});
            write_reg(slc_pkg::REG_LOG_SLOTS, {23'd0, slots_v});
            write_reg(slc_pkg::REG_FIRST_SLOT, {24'd0, first_v});
            repeat (32) begin
                smp = 16'($urandom_range(0, 65535));
                // Often start a recording and mostly leave it running; stop it now and then
                if (beat_phase == 2'd0)
                    btn = ($urandom_range(0, rec_active ? 9 : 2) == 0);
                else
                    btn = 1'($urandom_range(0, 1));
                send_word(smp, btn, 1'b0, 1'b0, 1'b0);
            end
        end

        drain_results();
        $display("Covered %0d samples under 16 register settings and three idle patterns.",
                 samples_sent);
        $display("Checked %0d result words: %0d slot writes, %0d log closes, %0d mismatches.",
                 words_checked, slot_writes_seen, log_closes, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("Timeout with %0d result words still expected.", pending_log_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
